### rtl/stbs_pkg.sv
// Shared types and constants for the sorted table binary search block.
// Used by the controller, datapath, top level and checker; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package stbs_pkg;

    localparam int VALUE_W   = 64;
    localparam int INDEX_W   = 10;
    localparam int ENTRIES_W = 11;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_EXACT = 2'd1;
    localparam logic [1:0] OP_LOWER = 2'd2;

    typedef struct packed {
        logic [1:0]                operation;
        logic [INDEX_W-1:0]        entry_index;
        logic signed [VALUE_W-1:0] entry_value;
        logic signed [VALUE_W-1:0] search_key;
    } request_t;

    typedef struct packed {
        logic                      found;
        logic [INDEX_W-1:0]        position;
        logic signed [VALUE_W-1:0] found_value;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_COMPARE,
        ST_REPORT
    } state_t;

    typedef struct packed {
        logic load_we;
        logic init;
        logic rd_en;
        logic update;
    } ctrl_cmd_t;

    typedef struct packed {
        logic range_open;
        logic exact_hit;
    } dp_status_t;

endpackage

`default_nettype wire

### rtl/stbs_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module stbs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/stbs_ctrl.sv
// Controller state machine for the binary search: sequences probe reads,
// bound updates and the result strobe. Depends on stbs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stbs_ctrl
    import stbs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic [1:0] operation,
    input  wire dp_status_t status,
    output ctrl_cmd_t       cmd,
    output logic            busy,
    output logic            done
);

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign accept = start && (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (operation inside {OP_EXACT, OP_LOWER}))
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = status.range_open ? ST_COMPARE : ST_REPORT;
            end
            ST_COMPARE:
            begin
                state_next = status.exact_hit ? ST_REPORT : ST_CHECK;
            end
            ST_REPORT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd     = '0;
        busy    = 1'b1;
        done    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy        = 1'b0;
                cmd.load_we = accept && (operation == OP_LOAD);
                cmd.init    = accept && (operation inside {OP_EXACT, OP_LOWER});
            end
            ST_CHECK:
            begin
                cmd.rd_en = status.range_open;
            end
            ST_COMPARE:
            begin
                cmd.update = 1'b1;
            end
            ST_REPORT:
            begin
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/stbs_datapath.sv
// Datapath for the binary search: table RAM, entry count register, search
// bounds, probe compare and result registers. Depends on stbs_pkg, stbs_ram.
`timescale 1ns / 1ps
`default_nettype none

module stbs_datapath
    import stbs_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire request_t             request,
    input  wire logic                 cfg_we,
    input  wire logic [ENTRIES_W-1:0] cfg_wdata,
    input  wire ctrl_cmd_t            cmd,
    output dp_status_t                status,
    output result_t                   result
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int MW = CW + 1;
    localparam int NW = (CW > ENTRIES_W) ? CW : ENTRIES_W;
    localparam int EW = (CW > INDEX_W) ? CW : INDEX_W;
    localparam int PW = (AW > INDEX_W) ? AW : INDEX_W;

    logic [ENTRIES_W-1:0]      entries_reg;
    logic [CW-1:0]             lo_reg;
    logic [CW-1:0]             hi_reg;
    logic [CW-1:0]             mid_reg;
    logic signed [VALUE_W-1:0] key_reg;
    logic                      exact_reg;
    logic                      hit_reg;
    logic [AW-1:0]             pos_reg;
    logic signed [VALUE_W-1:0] val_reg;

    logic [NW-1:0]             cfg_w;
    logic [NW-1:0]             depth_w;
    logic [NW-1:0]             sat_w;
    logic [CW-1:0]             count;
    logic [EW-1:0]             idx_w;
    logic                      load_ok;
    logic [MW-1:0]             sum_w;
    logic [CW-1:0]             mid;
    logic signed [VALUE_W-1:0] probe;
    logic                      probe_eq;
    logic                      probe_lt;
    logic [PW-1:0]             pos_w;
    logic [VALUE_W-1:0]        ram_rdata;

    // Entry count saturates at the table depth.
    assign cfg_w   = NW'(entries_reg);
    assign depth_w = NW'(TABLE_DEPTH);
    assign sat_w   = (cfg_w > depth_w) ? depth_w : cfg_w;
    assign count   = sat_w[CW-1:0];

    assign idx_w   = EW'(request.entry_index);
    assign load_ok = idx_w < EW'(TABLE_DEPTH);

    // Bounds are half open [lo, hi); the probe is the floor of the midpoint
    // of the inclusive range, which is only formed while lo < hi.
    assign sum_w = {1'b0, lo_reg} + {1'b0, hi_reg} - MW'(1);
    assign mid   = sum_w[MW-1:1];

    stbs_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.load_we && load_ok),
        .waddr (idx_w[AW-1:0]),
        .wdata (request.entry_value),
        .re    (cmd.rd_en),
        .raddr (mid[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign probe    = $signed(ram_rdata);
    assign probe_eq = (probe == key_reg);
    assign probe_lt = (probe < key_reg);

    assign status.range_open = (lo_reg < hi_reg);
    assign status.exact_hit  = exact_reg && probe_eq;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg <= '0;
            hit_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                entries_reg <= cfg_wdata;
            end
            if (cmd.init)
            begin
                hit_reg <= 1'b0;
            end
            else if (cmd.update && (exact_reg ? probe_eq : !probe_lt))
            begin
                hit_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.init)
        begin
            lo_reg    <= '0;
            hi_reg    <= count;
            key_reg   <= request.search_key;
            exact_reg <= (request.operation == OP_EXACT);
        end
        if (cmd.rd_en)
        begin
            mid_reg <= mid;
        end
        if (cmd.update)
        begin
            if (exact_reg)
            begin
                if (probe_eq)
                begin
                    pos_reg <= mid_reg[AW-1:0];
                    val_reg <= probe;
                end
                else if (probe_lt)
                begin
                    lo_reg <= mid_reg + CW'(1);
                end
                else
                begin
                    hi_reg <= mid_reg;
                end
            end
            else
            begin
                if (!probe_lt)
                begin
                    pos_reg <= mid_reg[AW-1:0];
                    val_reg <= probe;
                    hi_reg  <= mid_reg;
                end
                else
                begin
                    lo_reg <= mid_reg + CW'(1);
                end
            end
        end
    end

    assign pos_w              = PW'(pos_reg);
    assign result.found       = hit_reg;
    assign result.position    = hit_reg ? pos_w[INDEX_W-1:0] : '0;
    assign result.found_value = hit_reg ? val_reg : '0;

endmodule

`default_nettype wire

### rtl/sorted_table_binary_search.sv
// Sorted table binary search. A load item writes one entry and leaves busy
// low. A search item over N entries makes P probes, each a RAM read and then
// a compare, with P <= floor(log2 N)+1; it ends when the range is empty or an
// exact match is found, done is raised in the report state, and the next item
// is taken in the cycle after done. done is a one-cycle strobe.
// rst_n is asynchronous: the controller returns to idle and the entry count
// clears; table contents are not cleared and must be loaded before use.
`timescale 1ns / 1ps
`default_nettype none

module sorted_table_binary_search
    import stbs_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire request_t             request,
    input  wire logic                 cfg_we,
    input  wire logic [ENTRIES_W-1:0] cfg_wdata,
    output logic                      done,
    output result_t                   result
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    stbs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (request.operation),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy),
        .done      (done)
    );

    stbs_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

endmodule

`default_nettype wire

### rtl/stbs_checker.sv
// Port-level checks for sorted_table_binary_search, bound to the top level.
// Depends on stbs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stbs_checker
    import stbs_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     start,
    input wire logic     busy,
    input wire request_t request,
    input wire logic     done,
    input wire result_t  result
);

    // A result only appears while a search is in progress.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> busy)
        else $error("done strobe outside a search");

    // The strobe lasts one cycle.
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("done held for more than one cycle");

    // A load item completes at once and leaves the block free.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && request.operation == OP_LOAD) |=> !busy)
        else $error("load item raised busy");

    // A search item occupies the block.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (request.operation == OP_EXACT ||
                            request.operation == OP_LOWER)) |=> busy)
        else $error("search item did not raise busy");

    // A miss reports zero position and value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.found) |-> (result.position == '0 && result.found_value == '0))
        else $error("miss with nonzero payload");

endmodule

bind sorted_table_binary_search stbs_checker u_stbs_checker (.*);

`default_nettype wire
